@@ src/dvh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvh_pkg
// Shared types, field widths and float ordering helpers for the histogram.
// ----------------------------------------------------------------------------
package dvh_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned SmoothW = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned CumW    = 21;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // store one sample
    logic new_set;     // drop the previous data set first
    logic build_init;  // clear bin count and scan state
    logic scan_cmp;    // compare one sample word against the running minimum
    logic pass_end;    // close one pass: emit a bin if one was found
    logic sm_init;     // start smoothing at bin zero
    logic sm_acc;      // add one count word to the window sum
    logic sm_wr;       // write the window sum back, advance
    logic cnt_rd_sm;   // count memory read address from the smoothing window
    logic drain_init;  // restart drain index and running sum
    logic drain_out;   // register one bin as a result word
    logic empty_out;   // register the empty result word
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_end;
    logic found;
    logic smooth_on;
    logic j_end;
    logic sm_end;
    logic bins_zero;
    logic last;
    logic out_busy;
  } status_t;

  // Monotone unsigned key of a float pattern, -0 folded onto +0
  function automatic logic [SampleW-1:0] to_key(input logic [SampleW-1:0] x);
    logic [SampleW-1:0] v;
    v = (x == 32'h8000_0000) ? '0 : x;
    return v[SampleW-1] ? ~v : (v | 32'h8000_0000);
  endfunction

  function automatic logic [SampleW-1:0] from_key(input logic [SampleW-1:0] k);
    return k[SampleW-1] ? (k & 32'h7fff_ffff) : ~k;
  endfunction

endpackage

@@ src/dvh_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvh_if
// Valid/ready channels: operation words in, histogram bin words out.
// ----------------------------------------------------------------------------
interface dvh_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] sample;
  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

interface dvh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] bin_value;
  logic [10:0] bin_count;
  logic [20:0] cumulative_count;
  logic        last_bin;
  logic        empty_res;
  logic        overflow;
  modport source (output valid, output bin_value, output bin_count,
                  output cumulative_count, output last_bin, output empty_res,
                  output overflow, input ready);
  modport sink   (input valid, input bin_value, input bin_count,
                  input cumulative_count, input last_bin, input empty_res,
                  input overflow, output ready);
endinterface

@@ src/dvh_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvh_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dvh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write when enabled, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/dvh_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvh_ctrl
// Sequencer for load, bin build, smoothing and drain.
// ----------------------------------------------------------------------------
module dvh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_op_i,
  output logic             in_ready_o,
  input  dvh_pkg::status_t status_i,
  output dvh_pkg::cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_SCAN_RD  = 9'b000000010,
    ST_SCAN_CMP = 9'b000000100,
    ST_PASS_END = 9'b000001000,
    ST_SM_RD    = 9'b000010000,
    ST_SM_ACC   = 9'b000100000,
    ST_SM_WR    = 9'b001000000,
    ST_DR_RD    = 9'b010000000,
    ST_DR_OUT   = 9'b100000000
  } state_e;

  typedef enum logic [1:0] {
    PH_LOADING  = 2'd0,
    PH_DRAINING = 2'd1,
    PH_FINISHED = 2'd2
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && !status_i.out_busy;
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && !in_op_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.new_set = (phase_q != PH_LOADING);
          phase_d       = PH_LOADING;
        end else if (accept) begin
          if (phase_q != PH_DRAINING) begin
            cmd_o.build_init = 1'b1;
            state_d          = ST_SCAN_RD;
          end else begin
            state_d = ST_DR_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        state_d = status_i.scan_end ? ST_PASS_END : ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d        = ST_SCAN_RD;
      end
      ST_PASS_END: begin
        cmd_o.pass_end = 1'b1;
        if (status_i.found) begin
          state_d = ST_SCAN_RD;
        end else if (status_i.smooth_on) begin
          cmd_o.sm_init = 1'b1;
          state_d       = ST_SM_RD;
        end else begin
          cmd_o.drain_init = 1'b1;
          phase_d          = PH_DRAINING;
          state_d          = ST_DR_RD;
        end
      end
      ST_SM_RD: begin
        cmd_o.cnt_rd_sm = 1'b1;
        state_d         = ST_SM_ACC;
      end
      ST_SM_ACC: begin
        cmd_o.sm_acc = 1'b1;
        state_d      = status_i.j_end ? ST_SM_WR : ST_SM_RD;
      end
      ST_SM_WR: begin
        cmd_o.sm_wr = 1'b1;
        if (status_i.sm_end) begin
          cmd_o.drain_init = 1'b1;
          phase_d          = PH_DRAINING;
          state_d          = ST_DR_RD;
        end else begin
          state_d = ST_SM_RD;
        end
      end
      ST_DR_RD: begin
        if (status_i.bins_zero) begin
          cmd_o.empty_out = 1'b1;
          phase_d         = PH_FINISHED;
          state_d         = ST_IDLE;
        end else begin
          state_d = ST_DR_OUT;
        end
      end
      ST_DR_OUT: begin
        cmd_o.drain_out = 1'b1;
        if (status_i.last) begin
          phase_d = PH_FINISHED;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_LOADING;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

@@ src/dvh_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvh_datapath
// Sample and bin memories, minimum-search passes, smoothing and drain registers.
// ----------------------------------------------------------------------------
module dvh_datapath #(
  parameter int unsigned MaxSamples = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dvh_pkg::cmd_t                 cmd_i,
  output dvh_pkg::status_t              status_o,
  input  logic [dvh_pkg::SampleW-1:0]   sample_i,
  input  logic [dvh_pkg::SmoothW-1:0]   smooth_width_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [dvh_pkg::SampleW-1:0]   bin_value_o,
  output logic [dvh_pkg::CountW-1:0]    bin_count_o,
  output logic [dvh_pkg::CumW-1:0]      cumulative_count_o,
  output logic                          last_bin_o,
  output logic                          empty_res_o,
  output logic                          overflow_o
);

  localparam int unsigned AW = $clog2(MaxSamples);
  localparam int unsigned CW = $clog2(MaxSamples + 1);

  logic [CW-1:0] total_q, total_d, idx_q, idx_d, bins_q, bins_d, cnt_q, cnt_d;
  logic [CW-1:0] smi_q, smi_d, acc_q, acc_d, drain_q, drain_d;
  logic [dvh_pkg::SmoothW-1:0] smj_q, smj_d;
  logic [dvh_pkg::CumW-1:0]    run_q, run_d;
  logic [dvh_pkg::SampleW-1:0] prev_q, prev_d, best_q, best_d;
  logic dropped_q, dropped_d, have_prev_q, have_prev_d, found_q, found_d;
  logic out_valid_q, out_valid_d;

  logic                        full, s_we, bv_we, bc_we;
  logic [AW-1:0]               s_waddr, bin_waddr, sm_addr, c_raddr;
  logic [CW-1:0]               c_wdata, c_rdata;
  logic [dvh_pkg::SampleW-1:0] s_rdata, v_rdata, key, bv_wdata;
  logic                        cand;

  // Memories
  dvh_ram #(.Width(dvh_pkg::SampleW), .Depth(MaxSamples)) u_samples (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(sample_i),
    .raddr_i(idx_q[AW-1:0]), .rdata_o(s_rdata)
  );
  dvh_ram #(.Width(dvh_pkg::SampleW), .Depth(MaxSamples)) u_bin_values (
    .clk_i, .we_i(bv_we), .waddr_i(bin_waddr), .wdata_i(bv_wdata),
    .raddr_i(drain_q[AW-1:0]), .rdata_o(v_rdata)
  );
  dvh_ram #(.Width(CW), .Depth(MaxSamples)) u_bin_counts (
    .clk_i, .we_i(bc_we), .waddr_i(bin_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  // Load addressing
  assign full    = !cmd_i.new_set && (total_q == CW'(MaxSamples));
  assign s_waddr = cmd_i.new_set ? '0 : total_q[AW-1:0];
  assign s_we    = cmd_i.load && !full;

  // Bin and smoothing addressing
  assign sm_addr   = AW'(smi_q + CW'(smj_q));
  assign c_raddr   = cmd_i.cnt_rd_sm ? sm_addr : drain_q[AW-1:0];
  assign bin_waddr = cmd_i.sm_wr ? smi_q[AW-1:0] : bins_q[AW-1:0];
  assign bv_we     = cmd_i.pass_end && found_q;
  assign bc_we     = bv_we || cmd_i.sm_wr;
  assign bv_wdata  = dvh_pkg::from_key(best_q);
  assign c_wdata   = cmd_i.sm_wr ? acc_q : cnt_q;

  // Scan compare
  assign key  = dvh_pkg::to_key(s_rdata);
  assign cand = !have_prev_q || (key > prev_q);

  // Status
  assign status_o.scan_end  = (idx_q == total_q);
  assign status_o.found     = found_q;
  assign status_o.smooth_on = (smooth_width_i != '0) &&
                              (32'(smooth_width_i) < 32'(bins_q));
  assign status_o.j_end     = (smj_q == smooth_width_i);
  assign status_o.sm_end    = (32'(smi_q) + 32'd1 == 32'(bins_q) - 32'(smooth_width_i));
  assign status_o.bins_zero = (bins_q == '0);
  assign status_o.last      = (32'(drain_q) + 32'd1 >= 32'(bins_q));
  assign status_o.out_busy  = out_valid_q;

  // Next values
  always_comb begin
    total_d     = total_q;
    dropped_d   = dropped_q;
    idx_d       = idx_q;
    bins_d      = bins_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    best_d      = best_q;
    found_d     = found_q;
    smi_d       = smi_q;
    smj_d       = smj_q;
    acc_d       = acc_q;
    drain_d     = drain_q;
    run_d       = run_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      total_d   = (cmd_i.new_set ? '0 : total_q) + CW'(!full);
      dropped_d = !cmd_i.new_set && (dropped_q || full);
    end
    if (cmd_i.build_init) begin
      bins_d      = '0;
      idx_d       = '0;
      have_prev_d = 1'b0;
      found_d     = 1'b0;
    end
    if (cmd_i.scan_cmp) begin
      idx_d = idx_q + CW'(1);
      if (cand && (!found_q || key < best_q)) begin
        best_d  = key;
        cnt_d   = CW'(1);
        found_d = 1'b1;
      end else if (cand && key == best_q) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
    if (cmd_i.pass_end) begin
      idx_d   = '0;
      found_d = 1'b0;
      if (found_q) begin
        bins_d      = bins_q + CW'(1);
        prev_d      = best_q;
        have_prev_d = 1'b1;
      end
    end
    if (cmd_i.sm_init) begin
      smi_d = '0;
      smj_d = '0;
      acc_d = '0;
    end
    if (cmd_i.sm_acc) begin
      acc_d = acc_q + c_rdata;
      smj_d = smj_q + dvh_pkg::SmoothW'(1);
    end
    if (cmd_i.sm_wr) begin
      smi_d = smi_q + CW'(1);
      smj_d = '0;
      acc_d = '0;
    end
    if (cmd_i.drain_init) begin
      drain_d = '0;
      run_d   = '0;
    end
    if (cmd_i.drain_out) begin
      drain_d     = drain_q + CW'(1);
      run_d       = run_q + dvh_pkg::CumW'(c_rdata);
      out_valid_d = 1'b1;
    end
    if (cmd_i.empty_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      dropped_q   <= 1'b0;
      idx_q       <= '0;
      bins_q      <= '0;
      cnt_q       <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      best_q      <= '0;
      found_q     <= 1'b0;
      smi_q       <= '0;
      smj_q       <= '0;
      acc_q       <= '0;
      drain_q     <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q     <= total_d;
      dropped_q   <= dropped_d;
      idx_q       <= idx_d;
      bins_q      <= bins_d;
      cnt_q       <= cnt_d;
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      best_q      <= best_d;
      found_q     <= found_d;
      smi_q       <= smi_d;
      smj_q       <= smj_d;
      acc_q       <= acc_d;
      drain_q     <= drain_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.drain_out) begin
      bin_value_o        <= v_rdata;
      bin_count_o        <= dvh_pkg::CountW'(c_rdata);
      cumulative_count_o <= run_d;
      last_bin_o         <= status_o.last;
      empty_res_o        <= 1'b0;
      overflow_o         <= dropped_q;
    end else if (cmd_i.empty_out) begin
      bin_value_o        <= '0;
      bin_count_o        <= '0;
      cumulative_count_o <= '0;
      last_bin_o         <= 1'b1;
      empty_res_o        <= 1'b1;
      overflow_o         <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/distinct_value_histogram_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_value_histogram_core
// Sorted histogram of float samples with running cumulative counts.
// ----------------------------------------------------------------------------
// A load word stores one sample in the sample memory. A drain word normally
// reads the count and value memories, then registers the result word. The
// first drain of a data set first builds the bins: one pass over the sample
// memory per distinct value plus a closing pass, each sample read and then
// compared, then, with a nonzero window w below the bin count, each smoothed
// bin sums w+1 count words and writes the sum back, all through the single
// read port of the sample and count memories. No new word is taken while a result word waits.
module distinct_value_histogram_core #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dvh_in_if.sink     in_i,
  dvh_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i
);

  dvh_pkg::cmd_t    cmd;
  dvh_pkg::status_t status;
  logic [dvh_pkg::SmoothW-1:0] smooth_width_q;

  // Smoothing window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_width_q <= '0;
    end else if (cfg_we_i) begin
      smooth_width_q <= cfg_wdata_i;
    end
  end

  dvh_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_op_i(in_i.op), .in_ready_o(in_i.ready),
    .status_i(status), .cmd_o(cmd)
  );

  dvh_datapath #(.MaxSamples(MAX_SAMPLES)) u_datapath (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .status_o(status),
    .sample_i(in_i.sample), .smooth_width_i(smooth_width_q),
    .out_ready_i(out_o.ready), .out_valid_o(out_o.valid),
    .bin_value_o(out_o.bin_value), .bin_count_o(out_o.bin_count),
    .cumulative_count_o(out_o.cumulative_count), .last_bin_o(out_o.last_bin),
    .empty_res_o(out_o.empty_res), .overflow_o(out_o.overflow)
  );

`ifndef SYNTHESIS
  // No new word while a result word is held
  a_ready_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid) else $error("input ready with result pending");

  // Empty result is always the final bin
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.empty_res) |-> out_o.last_bin)
    else $error("empty result not marked last");

  // Running sum includes the current bin
  a_cum_ge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (21'(out_o.bin_count) <= out_o.cumulative_count))
    else $error("cumulative count below bin count");
`endif

endmodule
